FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the flood guard RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PFG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pfg assertion failed");

`define PFG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pfg assertion failed");

`else

`define PFG_ASSERT(lbl, clk, rstn, prop)

`define PFG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: hw/rtl/pfg_pkg.sv
`default_nettype none

package pfg_pkg;

  localparam int ID_BITS     = 10;
  localparam int TABLE_DEPTH = 1 << ID_BITS;
  localparam int COUNT_W     = 16;
  localparam int EPOCH_W     = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

  localparam logic [15:0] SEND_LIMIT_RST = 16'd200;
  localparam logic [15:0] LOG_COUNT_RST  = 16'd100;
  localparam logic [31:0] WINDOW_MS_RST  = 32'd60000;

  localparam logic [1:0] REG_SEND_LIMIT = 2'd0;
  localparam logic [1:0] REG_LOG_COUNT  = 2'd1;
  localparam logic [1:0] REG_WINDOW_MS  = 2'd2;
  localparam logic [1:0] REG_ENFORCE    = 2'd3;

  typedef struct packed {
    logic [9:0]  event_id;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        disconnect;
    logic        flood_seen;
    logic        warn_mark;
    logic        window_restarted;
    logic [15:0] over_count;
  } out_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [COUNT_W-1:0] cnt;
  } mem_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/per_id_packet_flood_guard_top.sv
// Channel   Ports                                   Handshake
// input     start, busy, in_data                    taken when start && !busy
// result    out_valid, out_data                     one-cycle strobe, no backpressure
// config    psel, penable, pwrite, paddr, pwdata,   APB write in access phase,
//           prdata, pready                          pready tied high
//
// One item per cycle while busy is low; each result passes through the s1 register, then the output register.
// Count table is a 1024 x 24 RAM tagged with a table epoch; a clear bumps the epoch.
// After reset a clearing pass rewrites all 1024 entries, one per cycle, busy high.
// When the epoch wraps (every 255th clear) busy is high in that item's cycle and
// for the clearing pass over all 1024 entries that follows.
// The receiver cannot stall; busy is the only input-side hold.
`default_nettype none
`include "assert_macros.svh"

module per_id_packet_flood_guard_top
  import pfg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] send_limit_r;
  logic [15:0] log_count_r;
  logic [31:0] window_ms_r;
  logic        enforce_r;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_limit_r <= SEND_LIMIT_RST;
      log_count_r  <= LOG_COUNT_RST;
      window_ms_r  <= WINDOW_MS_RST;
      enforce_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SEND_LIMIT: send_limit_r <= pwdata[15:0];
        REG_LOG_COUNT:  log_count_r  <= pwdata[15:0];
        REG_WINDOW_MS:  window_ms_r  <= pwdata;
        REG_ENFORCE:    enforce_r    <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SEND_LIMIT: prdata = {16'd0, send_limit_r};
      REG_LOG_COUNT:  prdata = {16'd0, log_count_r};
      REG_WINDOW_MS:  prdata = window_ms_r;
      REG_ENFORCE:    prdata = {31'd0, enforce_r};
      default:        prdata = '0;
    endcase
  end

  // control state
  logic               s1_v_r;
  in_item_t           s1_item_r;
  logic               sweep_r;
  logic [ID_BITS-1:0] sweep_idx_r;
  logic [EPOCH_W-1:0] cur_r, cur_nxt;
  logic               table_empty_r, table_empty_nxt;
  logic [31:0]        window_start_r, window_start_nxt;
  logic               fwd_v_r;
  logic [ID_BITS-1:0] fwd_id_r;
  mem_word_t          fwd_word_r;
  mem_word_t          rd_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  mem_word_t mem [TABLE_DEPTH];

  logic               accept;
  logic [ID_BITS-1:0] s1_id;
  mem_word_t          word;
  logic [COUNT_W-1:0] cnt_old, cnt;
  logic [31:0]        wstart, elapsed;
  logic               in_win, over_lim, flood, disc, warn, clear, wrap;
  logic               mem_we;
  logic [ID_BITS-1:0] mem_wa;
  mem_word_t          mem_wd;
  out_item_t          res;

  assign accept = start & ~busy;
  assign s1_id  = s1_item_r.event_id[ID_BITS-1:0];

  always_comb begin
    word     = (fwd_v_r && fwd_id_r == s1_id) ? fwd_word_r : rd_r;
    cnt_old  = (word.tag == cur_r) ? word.cnt : '0;
    cnt      = (cnt_old == COUNT_MAX) ? COUNT_MAX : cnt_old + 16'd1;
    wstart   = table_empty_r ? s1_item_r.now_ms : window_start_r;
    elapsed  = s1_item_r.now_ms - wstart;
    in_win   = elapsed < window_ms_r;
    warn     = (cnt == log_count_r) && in_win;
    over_lim = cnt >= send_limit_r;
    flood    = over_lim && in_win;
    disc     = flood && enforce_r;
    clear    = over_lim && !disc;
    wrap     = s1_v_r && clear && (cur_r == EPOCH_LAST);

    res.disconnect       = disc;
    res.flood_seen       = flood;
    res.warn_mark        = warn;
    res.window_restarted = clear;
    res.over_count       = over_lim ? cnt : '0;

    table_empty_nxt  = table_empty_r;
    window_start_nxt = window_start_r;
    cur_nxt          = cur_r;
    if (s1_v_r) begin
      table_empty_nxt  = clear;
      window_start_nxt = clear ? s1_item_r.now_ms : wstart;
      if (clear) begin
        cur_nxt = (cur_r == EPOCH_LAST) ? EPOCH_FIRST : cur_r + 8'd1;
      end
    end

    mem_we = s1_v_r | sweep_r;
    mem_wa = s1_v_r ? s1_id : sweep_idx_r;
    if (s1_v_r) begin
      mem_wd.tag = cur_r;
      mem_wd.cnt = cnt;
    end else begin
      mem_wd.tag = EPOCH_STALE;
      mem_wd.cnt = '0;
    end
  end

  assign busy      = sweep_r | wrap;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    rd_r <= mem[in_data.event_id[ID_BITS-1:0]];
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      sweep_r        <= 1'b1;
      sweep_idx_r    <= '0;
      cur_r          <= EPOCH_FIRST;
      table_empty_r  <= 1'b1;
      window_start_r <= '0;
      fwd_v_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      s1_v_r         <= accept;
      cur_r          <= cur_nxt;
      table_empty_r  <= table_empty_nxt;
      window_start_r <= window_start_nxt;
      fwd_v_r        <= s1_v_r;
      out_valid_r    <= s1_v_r;
      if (wrap) begin
        sweep_r     <= 1'b1;
        sweep_idx_r <= '0;
      end else if (sweep_r) begin
        sweep_idx_r <= sweep_idx_r + ID_BITS'(1);
        if (sweep_idx_r == '1) begin
          sweep_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    fwd_id_r   <= s1_id;
    fwd_word_r <= mem_wd;
    out_data_r <= res;
  end

  `PFG_ASSERT(a_no_item_in_sweep, clk, rst_n, sweep_r |-> !s1_v_r)
  `PFG_ASSERT(a_item_to_result, clk, rst_n, s1_v_r |=> out_valid_r)
  `PFG_ASSERT(a_accept_to_stage, clk, rst_n, accept |=> s1_v_r)
  `PFG_ASSERT(a_restart_empties, clk, rst_n, (out_valid_r && out_data_r.window_restarted) |-> table_empty_r)
  `PFG_ASSERT(a_disc_is_flood, clk, rst_n, (out_valid_r && out_data_r.disconnect) |-> out_data_r.flood_seen)
  `PFG_ASSERT(a_epoch_nonzero, clk, rst_n, cur_r != EPOCH_STALE)

endmodule

`default_nettype wire

FILE: tb/tb.sv
module tb;
  import pfg_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] val;
    in_item_t    pkt;
    logic        typed;
    out_item_t   verdict;
  } row_t;

  localparam int N_ROWS      = 26;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_ITEMS  = 20;
  localparam int CYCLE_LIMIT = 1000000;

  // after reset: limit 200, log 100, window 60000, enforce off
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd0, 32'd0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd1023, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
    '{ROW_CFG, REG_SEND_LIMIT, 32'd1, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd5, 32'd100}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 16'd1}},
    '{ROW_CFG, REG_ENFORCE, 32'd1, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd5, 32'd7}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd5, 32'd8}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd2}},
    '{ROW_CFG, REG_LOG_COUNT, 32'd3, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd5, 32'd9}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 16'd3}},
    '{ROW_CFG, REG_WINDOW_MS, 32'd0, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd5, 32'd9}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 16'd4}},
    '{ROW_CFG, REG_WINDOW_MS, 32'hFFFF_FFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_SEND_LIMIT, 32'h0000_FFFF, '0, 1'b0, '0},
    '{ROW_CFG, REG_LOG_COUNT, 32'd2, '0, 1'b0, '0},
    '{ROW_CFG, REG_ENFORCE, 32'd0, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd3, 32'hFFFF_FFFE}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
    // time wraps but stays inside the window
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd3, 32'd5}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0}},
    '{ROW_CFG, REG_SEND_LIMIT, 32'd0, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd7, 32'd50}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 16'd1}},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd7, 32'd60}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 16'd1}},
    '{ROW_CFG, REG_SEND_LIMIT, 32'd200, '0, 1'b0, '0},
    '{ROW_CFG, REG_LOG_COUNT, 32'd100, '0, 1'b0, '0},
    '{ROW_CFG, REG_WINDOW_MS, 32'd60000, '0, 1'b0, '0},
    '{ROW_CFG, REG_ENFORCE, 32'd0, '0, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd1023, 32'd60}, 1'b0, '0},
    '{ROW_ITEM, REG_SEND_LIMIT, 32'd0, '{10'd512, 32'h8000_0000}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_data = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  logic [31:0] prdata;
  logic        pready;

  per_id_packet_flood_guard_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // shadow of the guard's state and registers
  logic [15:0] id_count [TABLE_DEPTH];
  bit          id_live [TABLE_DEPTH];
  bit          table_clear = 1'b1;
  logic [31:0] win_open = '0;
  logic [15:0] lim_send = SEND_LIMIT_RST;
  logic [15:0] lim_log = LOG_COUNT_RST;
  logic [31:0] lim_window = WINDOW_MS_RST;
  bit          enforce_on = 1'b0;

  out_item_t   verdict_q [$];
  out_item_t   want;
  int          n_errors = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  function automatic out_item_t flood_guard_step(in_item_t pkt);
    int unsigned cnt;
    logic [31:0] age;
    bit          in_win;
    out_item_t   v;
    v = '0;
    if (table_clear) win_open = pkt.now_ms;
    cnt = id_live[pkt.event_id] ? id_count[pkt.event_id] : 0;
    if (cnt < 65535) cnt++;
    id_count[pkt.event_id] = cnt[15:0];
    id_live[pkt.event_id] = 1'b1;
    table_clear = 1'b0;
    age = pkt.now_ms - win_open;
    in_win = age < lim_window;
    if (cnt == lim_log && in_win) v.warn_mark = 1'b1;
    if (cnt >= lim_send) begin
      v.over_count = cnt[15:0];
      if (in_win) begin
        v.flood_seen = 1'b1;
        v.disconnect = enforce_on;
      end
      if (!v.disconnect) begin
        foreach (id_live[k]) id_live[k] = 1'b0;
        table_clear = 1'b1;
        win_open = pkt.now_ms;
        v.window_restarted = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic send_packet(in_item_t pkt, bit typed, out_item_t typed_v);
    out_item_t v;
    start <= 1'b1;
    in_data <= pkt;
    do @(posedge clk); while (busy);
    v = flood_guard_step(pkt);
    verdict_q.insert(verdict_q.size(), typed ? typed_v : v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    while (busy) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SEND_LIMIT: lim_send = val[15:0];
      REG_LOG_COUNT:  lim_log = val[15:0];
      REG_WINDOW_MS:  lim_window = val;
      REG_ENFORCE:    enforce_on = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        n_errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.disconnect !== want.disconnect) begin
          $display("%0t: disconnect exp %0d got %0d", $time, want.disconnect,
                   out_data.disconnect);
          n_errors++;
        end
        if (out_data.flood_seen !== want.flood_seen) begin
          $display("%0t: flood_seen exp %0d got %0d", $time, want.flood_seen,
                   out_data.flood_seen);
          n_errors++;
        end
        if (out_data.warn_mark !== want.warn_mark) begin
          $display("%0t: warn_mark exp %0d got %0d", $time, want.warn_mark,
                   out_data.warn_mark);
          n_errors++;
        end
        if (out_data.window_restarted !== want.window_restarted) begin
          $display("%0t: window_restarted exp %0d got %0d", $time, want.window_restarted,
                   out_data.window_restarted);
          n_errors++;
        end
        if (out_data.over_count !== want.over_count) begin
          $display("%0t: over_count exp %0d got %0d", $time, want.over_count,
                   out_data.over_count);
          n_errors++;
        end
      end
    end
  end

  int unsigned now_t;
  int unsigned pick;
  logic [15:0] p_send;
  logic [15:0] p_log;
  logic [31:0] p_window;
  in_item_t    pkt;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        drain();
        reg_write(DIR_ROWS[r].reg_idx, DIR_ROWS[r].val);
      end else begin
        send_packet(DIR_ROWS[r].pkt, DIR_ROWS[r].typed, DIR_ROWS[r].verdict);
      end
    end

    // one id held over the limit, kept counting by repeated disconnects
    drain();
    reg_write(REG_SEND_LIMIT, 32'd4);
    reg_write(REG_LOG_COUNT, 32'd2);
    reg_write(REG_WINDOW_MS, 32'hFFFF_FFFF);
    reg_write(REG_ENFORCE, 32'd1);
    pkt.event_id = 10'($urandom());
    now_t = $urandom();
    for (int i = 0; i < HOLD_ITEMS; i++) begin
      pkt.now_ms = now_t + i;
      send_packet(pkt, 1'b0, '0);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      p_send = (p == 3) ? 16'hFFFF : 16'($urandom_range(1, 12));
      if (p == 2) p_log = '0;
      else if (p == 6) p_log = 16'hFFFF;
      else p_log = 16'($urandom_range(0, 14));
      case (p % 4)
        0: p_window = 32'hFFFF_FFFF;
        1: p_window = '0;
        2: p_window = $urandom_range(2, 60);
        default: p_window = 32'd60000;
      endcase
      reg_write(REG_SEND_LIMIT, {16'd0, p_send});
      reg_write(REG_LOG_COUNT, {16'd0, p_log});
      reg_write(REG_WINDOW_MS, p_window);
      reg_write(REG_ENFORCE, 32'(p % 2));
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 62;
        default: idle_pct = 33;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 75) pkt.event_id = 10'($urandom_range(0, 3));
        else if (pick < 85) pkt.event_id = 10'h3FF;
        else pkt.event_id = 10'($urandom());
        if ($urandom_range(99) < 3) now_t = $urandom();
        else now_t = now_t + $urandom_range(0, 3);
        pkt.now_ms = now_t;
        send_packet(pkt, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
